// ===== sv/csd_pkg.sv =====
// Package for the CUSUM latency shift detector.
// Holds the default widths, the configuration register map and reset values.
// No dependencies.
package csd_pkg;

    // Default data path widths, handed to the top level as parameter defaults.
    localparam int FRACTION_BITS_DEF = 4;
    localparam int SUM_BITS_DEF      = 31;
    localparam int STAMP_BITS_DEF    = 48;
    localparam int LATENCY_BITS_DEF  = 16;

    // Width of the confirmed alert counter.
    localparam int ALERT_BITS = 32;

    // Configuration register widths.
    localparam int MEAN_BITS = 20;
    localparam int K_BITS    = 20;
    localparam int H_BITS    = 24;
    localparam int DUR_BITS  = 36;

    // Configuration port geometry.
    localparam int CFG_DATA_BITS  = 36;
    localparam int CFG_INDEX_BITS = 2;

    // Configuration reset values.
    localparam logic [MEAN_BITS-1:0] MEAN_RESET = MEAN_BITS'(3200);
    localparam logic [K_BITS-1:0]    K_RESET    = K_BITS'(320);
    localparam logic [H_BITS-1:0]    H_RESET    = H_BITS'(3200);
    localparam logic [DUR_BITS-1:0]  DUR_RESET  = DUR_BITS'(600000000);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BASELINE_MEAN = 2'd0,
        CFG_K_OFFSET      = 2'd1,
        CFG_H_LIMIT       = 2'd2,
        CFG_MIN_DURATION  = 2'd3
    } cfg_reg_t;

endpackage

// ===== sv/cusum_shift_detector.sv =====
// Two-sided CUSUM latency shift detector with a persistence window.
// Depends on csd_pkg for the register map, widths and reset values.
//
// The block takes one latency sample per clock on the slave stream and returns one result
// per sample on the master stream. A sample is held in an input register, the update of
// both saturating sums, the alarm test and the window logic run in a single combinational
// pass, and the result is loaded into an output register, so a new sample is taken in
// every cycle while the output side keeps up. That rate is set by the feedback of the
// sums, the window state and the alert counter, which are all updated in the same cycle
// that a result is loaded. Configuration registers are written through the plain write
// port and take effect on the next sample that enters the update stage.
module cusum_shift_detector
    import csd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int SUM_BITS      = SUM_BITS_DEF,
    parameter int STAMP_BITS    = STAMP_BITS_DEF,
    parameter int LATENCY_BITS  = LATENCY_BITS_DEF,
    localparam int IN_TDATA_BITS  = ((LATENCY_BITS + STAMP_BITS + 7) / 8) * 8,
    localparam int OUT_FIELD_BITS = 3 + STAMP_BITS + ALERT_BITS + SUM_BITS + LATENCY_BITS,
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Configuration write port.
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    // Sample stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // From bit 0 up: latency, now_ticks.
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // Bit 0: irq_seen.
    input  logic                      s_tuser,

    // Result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // From bit 0 up: alarm_now, in_window, alert_fired, elapsed_ticks, alert_total,
    // score_high, latency_echo, zero padding.
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    // Arithmetic widths: the widest operand plus a bit of headroom and a sign bit.
    localparam int X_BITS    = LATENCY_BITS + FRACTION_BITS;
    localparam int MAX_A     = (SUM_BITS > X_BITS) ? SUM_BITS : X_BITS;
    localparam int VAL_BITS  = (MAX_A > H_BITS) ? MAX_A : H_BITS;
    localparam int CALC_BITS = VAL_BITS + 2;
    localparam int CMP_BITS  = (STAMP_BITS > DUR_BITS) ? STAMP_BITS : DUR_BITS;

    localparam logic signed [CALC_BITS-1:0] SUM_TOP =
        {{(CALC_BITS - SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

    // Configuration registers.
    logic [MEAN_BITS-1:0]    mean_reg;
    logic [K_BITS-1:0]       k_reg;
    logic [H_BITS-1:0]       h_reg;
    logic [DUR_BITS-1:0]     dur_reg;

    // Input stage.
    logic                    in_valid_reg;
    logic [LATENCY_BITS-1:0] in_lat_reg;
    logic                    in_irq_reg;
    logic [STAMP_BITS-1:0]   in_now_reg;

    // Detector state.
    logic [SUM_BITS-1:0]     sum_high_reg;
    logic [SUM_BITS-1:0]     sum_high_next;
    logic [SUM_BITS-1:0]     sum_low_reg;
    logic [SUM_BITS-1:0]     sum_low_next;
    logic                    window_open_reg;
    logic                    window_open_next;
    logic [STAMP_BITS-1:0]   window_start_reg;
    logic [STAMP_BITS-1:0]   window_start_next;
    logic [ALERT_BITS-1:0]   count_reg;
    logic [ALERT_BITS-1:0]   count_next;

    // Output stage.
    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_next;

    // Update logic.
    logic                        out_slot;
    logic                        load_out;
    logic signed [CALC_BITS-1:0] x_ext;
    logic signed [CALC_BITS-1:0] mean_ext;
    logic signed [CALC_BITS-1:0] k_ext;
    logic signed [CALC_BITS-1:0] hi_raw;
    logic signed [CALC_BITS-1:0] lo_raw;
    logic [SUM_BITS-1:0]         hi_clamp;
    logic [SUM_BITS-1:0]         lo_clamp;
    logic                        alarm;
    logic                        open_now;
    logic                        was_open;
    logic [STAMP_BITS-1:0]       start_eff;
    logic [STAMP_BITS-1:0]       elapsed;
    logic [STAMP_BITS-1:0]       elapsed_out;
    logic                        expired;
    logic                        fire;
    logic                        close_win;
    logic [SUM_BITS-1:0]         score;

    // Handshake: the output register frees a slot when empty or being taken.
    assign out_slot = !out_valid_reg || m_tready;
    assign load_out = in_valid_reg && out_slot;
    assign s_tready = !in_valid_reg || out_slot;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= MEAN_RESET;
            k_reg    <= K_RESET;
            h_reg    <= H_RESET;
            dur_reg  <= DUR_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BASELINE_MEAN: mean_reg <= cfg_wdata[MEAN_BITS-1:0];
                CFG_K_OFFSET:      k_reg    <= cfg_wdata[K_BITS-1:0];
                CFG_H_LIMIT:       h_reg    <= cfg_wdata[H_BITS-1:0];
                CFG_MIN_DURATION:  dur_reg  <= cfg_wdata[DUR_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Input register: loads whenever the stage can move.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_lat_reg <= s_tdata[LATENCY_BITS-1:0];
            in_now_reg <= s_tdata[LATENCY_BITS +: STAMP_BITS];
            in_irq_reg <= s_tuser;
        end
    end

    // Saturating sum update in sigma-scaled fixed point.
    always_comb
    begin
        x_ext    = CALC_BITS'(in_lat_reg) << FRACTION_BITS;
        mean_ext = CALC_BITS'(mean_reg);
        k_ext    = CALC_BITS'(k_reg);
        hi_raw   = CALC_BITS'(sum_high_reg) + x_ext - mean_ext - k_ext;
        lo_raw   = CALC_BITS'(sum_low_reg) - x_ext + mean_ext - k_ext;

        if (hi_raw[CALC_BITS-1])
            hi_clamp = '0;
        else if (hi_raw > SUM_TOP)
            hi_clamp = '1;
        else
            hi_clamp = hi_raw[SUM_BITS-1:0];

        if (lo_raw[CALC_BITS-1])
            lo_clamp = '0;
        else if (lo_raw > SUM_TOP)
            lo_clamp = '1;
        else
            lo_clamp = lo_raw[SUM_BITS-1:0];
    end

    // Alarm, window and alert decisions.
    always_comb
    begin
        alarm = !in_irq_reg &&
                ((VAL_BITS'(hi_clamp) > VAL_BITS'(h_reg)) ||
                 (VAL_BITS'(lo_clamp) > VAL_BITS'(h_reg)));

        // A window opened by this sample starts at this sample's timestamp.
        open_now  = window_open_reg || alarm;
        start_eff = window_open_reg ? window_start_reg : in_now_reg;
        elapsed   = in_now_reg - start_eff;
        was_open  = in_irq_reg ? window_open_reg : open_now;
        elapsed_out = was_open ? elapsed : '0;
        expired   = CMP_BITS'(elapsed) >= CMP_BITS'(dur_reg);

        fire      = !in_irq_reg && open_now && alarm && expired;
        close_win = !in_irq_reg && open_now && (!alarm || expired);

        window_open_next  = in_irq_reg ? window_open_reg : (open_now && !close_win);
        window_start_next = (!in_irq_reg && alarm && !window_open_reg) ?
                            in_now_reg : window_start_reg;

        // An interrupt, a closing window or a fired alert clears both sums.
        if (in_irq_reg || close_win)
        begin
            sum_high_next = '0;
            sum_low_next  = '0;
        end
        else
        begin
            sum_high_next = hi_clamp;
            sum_low_next  = lo_clamp;
        end

        count_next = count_reg + ALERT_BITS'(fire);
        score      = in_irq_reg ? '0 : hi_clamp;

        out_data_next = OUT_TDATA_BITS'({in_lat_reg, score, count_next, elapsed_out,
                                         fire, window_open_next, alarm});
    end

    // State update, one sample per loaded result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_high_reg     <= '0;
            sum_low_reg      <= '0;
            window_open_reg  <= 1'b0;
            window_start_reg <= '0;
            count_reg        <= '0;
        end
        else if (load_out)
        begin
            sum_high_reg     <= sum_high_next;
            sum_low_reg      <= sum_low_next;
            window_open_reg  <= window_open_next;
            window_start_reg <= window_start_next;
            count_reg        <= count_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_slot)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A fired alert always closes the window.
    a_fire_closes: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && fire |=> !window_open_reg)
        else $error("window still open after an alert fired");

    // The alert count moves by one on a fired alert.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("alert count did not advance on a fired alert");

    // The alert count holds when no result is loaded.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load_out |=> $stable(count_reg))
        else $error("alert count changed without a result");

    // An interrupt sample reports no alarm and no alert.
    a_irq_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && in_irq_reg |=> !m_tdata[0] && !m_tdata[2])
        else $error("interrupt sample raised an alarm or alert");

    // An empty output register never stalls the input side.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");
`endif

endmodule
